FILE: sv/efd_pkg.sv
// Shared types and constants for the mesh boundary edge finder.
`default_nettype none
package efd_pkg;

  localparam int EDGE_SLOTS_DEF = 64;
  localparam int INDEX_BITS_DEF = 16;

  // Vertex count register
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 16'd3;

  // Use count codes of a table entry
  localparam logic [1:0] USE_ONCE  = 2'd1;
  localparam logic [1:0] USE_TWICE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE1,
    ST_EDGE2,
    ST_EMIT
  } state_e;

  // Per-cycle command broadcast to every table lane
  typedef struct packed {
    logic edge_en;
    logic alloc;
    logic shift;
  } lane_ctl_t;

  // Combined lookup result over all lanes
  typedef struct packed {
    logic hit;
    logic hit_once;
  } merge_t;

endpackage
`default_nettype wire

FILE: sv/efd_lane.sv
// One edge table entry: stores an undirected edge, matches a key, counts uses.
`default_nettype none
module efd_lane #(
  parameter int W       = efd_pkg::INDEX_BITS_DEF,
  parameter int CNT_W   = 7,
  parameter int LANE_ID = 0
) (
  input  wire logic             clk_i,
  input  wire efd_pkg::lane_ctl_t ctl_i,
  input  wire logic [CNT_W-1:0] used_i,
  input  wire logic [W-1:0]     key_lo_i,
  input  wire logic [W-1:0]     key_hi_i,
  input  wire logic             key_rev_i,
  input  wire logic [W-1:0]     nxt_lo_i,
  input  wire logic [W-1:0]     nxt_hi_i,
  input  wire logic             nxt_rev_i,
  input  wire logic [1:0]       nxt_cnt_i,
  output logic [W-1:0]          lo_o,
  output logic [W-1:0]          hi_o,
  output logic                  rev_o,
  output logic [1:0]            cnt_o,
  output logic                  match_o,
  output logic                  once_o
);

  logic [W-1:0] lo_q, hi_q;
  logic         rev_q;
  logic [1:0]   cnt_q;
  logic         valid;
  logic         here;

  assign valid   = CNT_W'(LANE_ID) < used_i;
  assign here    = used_i == CNT_W'(LANE_ID);
  assign match_o = valid && (lo_q == key_lo_i) && (hi_q == key_hi_i);
  assign once_o  = cnt_q == efd_pkg::USE_ONCE;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      // advance toward the head during emission
      lo_q  <= nxt_lo_i;
      hi_q  <= nxt_hi_i;
      rev_q <= nxt_rev_i;
      cnt_q <= nxt_cnt_i;
    end else if (ctl_i.edge_en && match_o) begin
      cnt_q <= efd_pkg::USE_TWICE;
    end else if (ctl_i.alloc && here) begin
      lo_q  <= key_lo_i;
      hi_q  <= key_hi_i;
      rev_q <= key_rev_i;
      cnt_q <= efd_pkg::USE_ONCE;
    end
  end

  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign rev_o = rev_q;
  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

FILE: sv/efd_merge.sv
// Merge of the per-lane match flags into one lookup result.
`default_nettype none
module efd_merge #(
  parameter int EDGE_SLOTS = efd_pkg::EDGE_SLOTS_DEF
) (
  input  wire logic [EDGE_SLOTS-1:0] match_i,
  input  wire logic [EDGE_SLOTS-1:0] once_i,
  output efd_pkg::merge_t            res_o
);

  // entries are unique, so at most one lane matches
  assign res_o.hit      = |match_i;
  assign res_o.hit_once = |(match_i & once_i);

endmodule
`default_nettype wire

FILE: sv/mesh_boundary_edge_finder.sv
// Edges a-b, b-c, c-a of a triangle go one per cycle through the lane compare and update, in the
// states IDLE (at the accept), EDGE1, EDGE2; input stalls outside IDLE. After the final triangle
// the table shifts one entry per cycle toward the head, unless a boundary edge there meets a
// stalled output; it enters the output register as it leaves the head. With none left the counters
// clear. Reset clears control state and sets vertex_count to 3; table contents are not cleared.
`default_nettype none
module mesh_boundary_edge_finder #(
  parameter int EDGE_SLOTS = efd_pkg::EDGE_SLOTS_DEF,
  parameter int INDEX_BITS = efd_pkg::INDEX_BITS_DEF,
  parameter int BACK_W = ((INDEX_BITS > efd_pkg::CFG_W) ? INDEX_BITS : efd_pkg::CFG_W) + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [efd_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [INDEX_BITS-1:0]    vertex_a_i,
  input  wire logic [INDEX_BITS-1:0]    vertex_b_i,
  input  wire logic [INDEX_BITS-1:0]    vertex_c_i,
  input  wire logic                     final_triangle_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [INDEX_BITS-1:0]         edge_start_o,
  output logic [INDEX_BITS-1:0]         edge_end_o,
  output logic [BACK_W-1:0]             back_start_o,
  output logic [BACK_W-1:0]             back_end_o,
  output logic                          last_edge_o,
  output logic                          table_overflow_o
);

  localparam int W     = INDEX_BITS;
  localparam int CNT_W = $clog2(EDGE_SLOTS + 1);

  efd_pkg::state_e state_q, state_d;

  logic [W-1:0] a_q, b_q, c_q;
  logic         final_q;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] bound_q, bound_d;
  logic         ovf_q, ovf_d;
  logic [efd_pkg::CFG_W-1:0] vc_q;

  logic         out_valid_q;
  logic [W-1:0] out_s_q, out_e_q;
  logic [BACK_W-1:0] out_bs_q, out_be_q;
  logic         out_last_q, out_ovf_q;

  logic         in_acc;
  logic         edge_en, shift, load_out, done;
  logic [W-1:0] key_p, key_q, key_lo, key_hi;
  logic         key_rev;
  logic         room, alloc, out_free;
  efd_pkg::lane_ctl_t ctl;
  efd_pkg::merge_t    mres;

  logic [W-1:0] lo_w [EDGE_SLOTS];
  logic [W-1:0] hi_w [EDGE_SLOTS];
  logic         rev_w [EDGE_SLOTS];
  logic [1:0]   cnt_w [EDGE_SLOTS];
  logic [W-1:0] nxt_lo_w [EDGE_SLOTS];
  logic [W-1:0] nxt_hi_w [EDGE_SLOTS];
  logic         nxt_rev_w [EDGE_SLOTS];
  logic [1:0]   nxt_cnt_w [EDGE_SLOTS];
  logic [EDGE_SLOTS-1:0] match_w, once_w;

  logic [W-1:0] head_s, head_e;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != efd_pkg::ST_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      efd_pkg::ST_IDLE:  if (in_acc) state_d = efd_pkg::ST_EDGE1;
      efd_pkg::ST_EDGE1: state_d = efd_pkg::ST_EDGE2;
      efd_pkg::ST_EDGE2: state_d = final_q ? efd_pkg::ST_EMIT : efd_pkg::ST_IDLE;
      efd_pkg::ST_EMIT:  if (bound_q == '0) state_d = efd_pkg::ST_IDLE;
      default:           state_d = efd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    edge_en  = 1'b0;
    shift    = 1'b0;
    load_out = 1'b0;
    done     = 1'b0;
    key_p    = vertex_a_i;
    key_q    = vertex_b_i;
    case (state_q)
      efd_pkg::ST_IDLE: begin
        edge_en = in_acc;
      end
      efd_pkg::ST_EDGE1: begin
        edge_en = 1'b1;
        key_p   = b_q;
        key_q   = c_q;
      end
      efd_pkg::ST_EDGE2: begin
        edge_en = 1'b1;
        key_p   = c_q;
        key_q   = a_q;
      end
      efd_pkg::ST_EMIT: begin
        if (bound_q == '0) begin
          done = 1'b1;
        end else if (!once_w[0]) begin
          // drop an interior edge at the head
          shift = 1'b1;
        end else if (out_free) begin
          shift    = 1'b1;
          load_out = 1'b1;
        end
      end
      default: begin
        edge_en = 1'b0;
      end
    endcase
  end

  assign key_lo  = (key_p < key_q) ? key_p : key_q;
  assign key_hi  = (key_p < key_q) ? key_q : key_p;
  assign key_rev = key_p > key_q;

  assign room  = used_q < CNT_W'(EDGE_SLOTS);
  assign alloc = edge_en && !mres.hit && room;

  assign ctl.edge_en = edge_en;
  assign ctl.alloc   = alloc;
  assign ctl.shift   = shift;

  for (genvar i = 0; i < EDGE_SLOTS; i++) begin : g_lane
    if (i == EDGE_SLOTS - 1) begin : g_tail
      assign nxt_lo_w[i]  = lo_w[i];
      assign nxt_hi_w[i]  = hi_w[i];
      assign nxt_rev_w[i] = rev_w[i];
      assign nxt_cnt_w[i] = cnt_w[i];
    end else begin : g_body
      assign nxt_lo_w[i]  = lo_w[i+1];
      assign nxt_hi_w[i]  = hi_w[i+1];
      assign nxt_rev_w[i] = rev_w[i+1];
      assign nxt_cnt_w[i] = cnt_w[i+1];
    end

    efd_lane #(
      .W       (W),
      .CNT_W   (CNT_W),
      .LANE_ID (i)
    ) u_lane (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .used_i    (used_q),
      .key_lo_i  (key_lo),
      .key_hi_i  (key_hi),
      .key_rev_i (key_rev),
      .nxt_lo_i  (nxt_lo_w[i]),
      .nxt_hi_i  (nxt_hi_w[i]),
      .nxt_rev_i (nxt_rev_w[i]),
      .nxt_cnt_i (nxt_cnt_w[i]),
      .lo_o      (lo_w[i]),
      .hi_o      (hi_w[i]),
      .rev_o     (rev_w[i]),
      .cnt_o     (cnt_w[i]),
      .match_o   (match_w[i]),
      .once_o    (once_w[i])
    );
  end

  efd_merge #(
    .EDGE_SLOTS (EDGE_SLOTS)
  ) u_merge (
    .match_i (match_w),
    .once_i  (once_w),
    .res_o   (mres)
  );

  // bookkeeping counters
  always_comb begin
    used_d  = used_q;
    bound_d = bound_q;
    ovf_d   = ovf_q;
    if (done) begin
      used_d  = '0;
      bound_d = '0;
      ovf_d   = 1'b0;
    end else if (edge_en) begin
      if (alloc) begin
        used_d  = used_q + CNT_W'(1);
        bound_d = bound_q + CNT_W'(1);
      end else if (mres.hit_once) begin
        bound_d = bound_q - CNT_W'(1);
      end else if (!mres.hit) begin
        ovf_d = 1'b1;
      end
    end else if (shift) begin
      used_d = used_q - CNT_W'(1);
      if (load_out) bound_d = bound_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efd_pkg::ST_IDLE;
      used_q      <= '0;
      bound_q     <= '0;
      ovf_q       <= 1'b0;
      vc_q        <= efd_pkg::VERTEX_COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      bound_q <= bound_d;
      ovf_q   <= ovf_d;
      if (cfg_valid_i && cfg_ready_o) vc_q <= cfg_data_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign head_s = rev_w[0] ? hi_w[0] : lo_w[0];
  assign head_e = rev_w[0] ? lo_w[0] : hi_w[0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q     <= vertex_a_i;
      b_q     <= vertex_b_i;
      c_q     <= vertex_c_i;
      final_q <= final_triangle_i;
    end
    if (load_out) begin
      out_s_q    <= head_s;
      out_e_q    <= head_e;
      out_bs_q   <= BACK_W'(vc_q) + BACK_W'(head_s);
      out_be_q   <= BACK_W'(vc_q) + BACK_W'(head_e);
      out_last_q <= bound_q == CNT_W'(1);
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_start_o     = out_s_q;
  assign edge_end_o       = out_e_q;
  assign back_start_o     = out_bs_q;
  assign back_end_o       = out_be_q;
  assign last_edge_o      = out_last_q;
  assign table_overflow_o = out_ovf_q;

endmodule
`default_nettype wire

FILE: sv/efd_checker.sv
// Port-level checks for the mesh boundary edge finder, bound to the top level.
`default_nettype none
module efd_checker #(
  parameter int INDEX_BITS = efd_pkg::INDEX_BITS_DEF,
  parameter int BACK_W     = efd_pkg::CFG_W + 1
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [INDEX_BITS-1:0] edge_start_o,
  input wire logic [INDEX_BITS-1:0] edge_end_o,
  input wire logic [BACK_W-1:0]     back_start_o,
  input wire logic [BACK_W-1:0]     back_end_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edge_start_o) && $stable(back_start_o))
    else $error("stalled result changed");

  // both rim indices carry the same vertex count offset
  a_back_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (back_start_o - BACK_W'(edge_start_o)) ==
                    (back_end_o - BACK_W'(edge_end_o)))
    else $error("back rim offsets differ");

  // input stays stalled while an accepted triangle's remaining edges go through the table
  a_tri_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("triangle accepted too soon");

endmodule

bind mesh_boundary_edge_finder efd_checker #(
  .INDEX_BITS (INDEX_BITS),
  .BACK_W     (BACK_W)
) u_efd_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the mesh boundary edge finder.
`timescale 1ns / 1ps
module testbench;

  localparam int IDX_W = efd_pkg::INDEX_BITS_DEF;
  localparam int BACK_W = IDX_W + 1;
  localparam int SLOTS = efd_pkg::EDGE_SLOTS_DEF;
  localparam int VC_W = efd_pkg::CFG_W;
  // table walk after a final triangle plus the clearing of the counters, with margin
  localparam int SETTLE_CYCLES = SLOTS + 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {
    SHAPE_FAN,
    SHAPE_STRIP,
    SHAPE_POOL,
    SHAPE_NOISE
  } shape_e;

  typedef struct {
    logic [IDX_W-1:0]  edge_start;
    logic [IDX_W-1:0]  edge_end;
    logic [BACK_W-1:0] back_start;
    logic [BACK_W-1:0] back_end;
    logic              last_edge;
    logic              overflow;
  } boundary_edge_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [VC_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [IDX_W-1:0] vertex_a_i;
  logic [IDX_W-1:0] vertex_b_i;
  logic [IDX_W-1:0] vertex_c_i;
  logic final_triangle_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [IDX_W-1:0] edge_start_o;
  logic [IDX_W-1:0] edge_end_o;
  logic [BACK_W-1:0] back_start_o;
  logic [BACK_W-1:0] back_end_o;
  logic last_edge_o;
  logic table_overflow_o;

  // edge table mirror
  logic [IDX_W-1:0] lo_end [SLOTS];
  logic [IDX_W-1:0] hi_end [SLOTS];
  logic             flipped [SLOTS];
  logic [1:0]       uses [SLOTS];
  int unsigned      fill;
  logic             dropped;
  logic [VC_W-1:0]  vtx_count;

  boundary_edge_t boundary_q[$];
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  bit quiet;
  int hold_cycles;
  int stall_burst = 0;

  mesh_boundary_edge_finder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .vertex_a_i       (vertex_a_i),
    .vertex_b_i       (vertex_b_i),
    .vertex_c_i       (vertex_c_i),
    .final_triangle_i (final_triangle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_start_o     (edge_start_o),
    .edge_end_o       (edge_end_o),
    .back_start_o     (back_start_o),
    .back_end_o       (back_end_o),
    .last_edge_o      (last_edge_o),
    .table_overflow_o (table_overflow_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver: a long hold-off on request, else random stall bursts unless quiet
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst = $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : check_results
    boundary_edge_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (boundary_q.size() == 0) begin
        log_failure($sformatf("unexpected edge %0d->%0d at cycle %0d",
                              edge_start_o, edge_end_o, cycle_count));
      end else begin
        want = boundary_q.pop_front();
        if (edge_start_o !== want.edge_start || edge_end_o !== want.edge_end ||
            back_start_o !== want.back_start || back_end_o !== want.back_end ||
            last_edge_o !== want.last_edge || table_overflow_o !== want.overflow)
          log_failure($sformatf({"edge mismatch: expected %0d->%0d back %0d/%0d last %0b ",
                                 "ovf %0b, got %0d->%0d back %0d/%0d last %0b ovf %0b"},
                                want.edge_start, want.edge_end, want.back_start,
                                want.back_end, want.last_edge, want.overflow,
                                edge_start_o, edge_end_o, back_start_o, back_end_o,
                                last_edge_o, table_overflow_o));
      end
    end
  end

  task automatic note_edge(input logic [IDX_W-1:0] p, input logic [IDX_W-1:0] q);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    bit found;
    int i;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    found = 1'b0;
    for (i = 0; i < fill; i++) begin
      if (!found && lo_end[i] == lo && hi_end[i] == hi) begin
        found = 1'b1;
        if (uses[i] == efd_pkg::USE_ONCE) uses[i] = efd_pkg::USE_TWICE;
      end
    end
    if (!found) begin
      if (fill < SLOTS) begin
        lo_end[fill] = lo;
        hi_end[fill] = hi;
        flipped[fill] = (p > q);
        uses[fill] = efd_pkg::USE_ONCE;
        fill++;
      end else begin
        dropped = 1'b1;
      end
    end
  endtask

  // Add one triangle; on the final one queue the single-use edges in table order
  task automatic predict_triangle(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                  input logic [IDX_W-1:0] c, input logic fin);
    boundary_edge_t e;
    int first;
    int i;
    note_edge(a, b);
    note_edge(b, c);
    note_edge(c, a);
    if (fin) begin
      first = boundary_q.size();
      for (i = 0; i < fill; i++) begin
        if (uses[i] == efd_pkg::USE_ONCE) begin
          e.edge_start = flipped[i] ? hi_end[i] : lo_end[i];
          e.edge_end   = flipped[i] ? lo_end[i] : hi_end[i];
          e.back_start = {1'b0, vtx_count} + {1'b0, e.edge_start};
          e.back_end   = {1'b0, vtx_count} + {1'b0, e.edge_end};
          e.last_edge  = 1'b0;
          e.overflow   = dropped;
          boundary_q.insert(boundary_q.size(), e);
        end
      end
      if (boundary_q.size() > first) boundary_q[boundary_q.size()-1].last_edge = 1'b1;
      fill = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic send_triangle(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                               input logic [IDX_W-1:0] c, input logic fin);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_a_i <= a;
    vertex_b_i <= b;
    vertex_c_i <= c;
    final_triangle_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_triangle(a, b, c, fin);
  endtask

  // Drop valid, wait for every expected edge, then let the table walk finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (boundary_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VC_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    vtx_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_surface(input shape_e shape, input int ntri);
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vb;
    logic [IDX_W-1:0] vc;
    logic [IDX_W-1:0] pool [4];
    bit closed;
    int i;
    int k;
    base = IDX_W'($urandom);
    closed = (ntri >= 3) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < 4; k++) pool[k] = base + IDX_W'($urandom_range(0, 2));
    for (i = 0; i < ntri; i++) begin
      case (shape)
        SHAPE_FAN: begin
          va = base;
          vb = base + IDX_W'(1 + i);
          vc = closed ? base + IDX_W'(1 + (i + 1) % ntri) : base + IDX_W'(2 + i);
        end
        SHAPE_STRIP: begin
          // alternate the winding so shared edges run opposite ways
          va = base + IDX_W'(i + (i % 2));
          vb = base + IDX_W'(i + 1 - (i % 2));
          vc = base + IDX_W'(i + 2);
        end
        SHAPE_POOL: begin
          va = pool[$urandom_range(0, 3)];
          vb = pool[$urandom_range(0, 3)];
          vc = pool[$urandom_range(0, 3)];
        end
        default: begin
          va = IDX_W'($urandom);
          vb = IDX_W'($urandom);
          vc = IDX_W'($urandom);
        end
      endcase
      send_triangle(va, vb, vc, i == ntri - 1);
    end
  endtask

  task automatic test_single_triangles();
    send_triangle(16'd0, 16'hFFFF, 16'd1, 1'b1);
    // degenerate edge survives, the other two cancel
    send_triangle(16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    // every edge collapses onto one degenerate entry: no boundary
    send_triangle(16'd0, 16'd0, 16'd0, 1'b1);
    send_triangle(16'h5555, 16'hAAAA, 16'h0F0F, 1'b0);
    send_triangle(16'hAAAA, 16'h5555, 16'hF0F0, 1'b1);
  endtask

  task automatic test_shared_and_closed();
    send_triangle(16'd10, 16'd11, 16'd12, 1'b0);
    send_triangle(16'd12, 16'd11, 16'd13, 1'b1);
    // closed tetrahedron: every edge used twice
    send_triangle(16'd0, 16'd1, 16'd2, 1'b0);
    send_triangle(16'd0, 16'd3, 16'd1, 1'b0);
    send_triangle(16'd1, 16'd3, 16'd2, 1'b0);
    send_triangle(16'd0, 16'd2, 16'd3, 1'b1);
  endtask

  task automatic test_vertex_count_extremes();
    wait_idle();
    write_vertex_count(16'hFFFF);
    send_triangle(16'hFFFF, 16'd0, 16'h8000, 1'b1);
    wait_idle();
    write_vertex_count(16'd0);
    send_triangle(16'd1, 16'd2, 16'hFFFF, 1'b1);
    wait_idle();
    write_vertex_count(16'd1);
    send_surface(SHAPE_FAN, 3);
    wait_idle();
    write_vertex_count(efd_pkg::VERTEX_COUNT_RESET);
  endtask

  task automatic test_random_surfaces(input int n_items);
    int sent;
    int ntri;
    int pick;
    shape_e shape;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      shape = (pick < 40) ? SHAPE_FAN : (pick < 70) ? SHAPE_STRIP :
              (pick < 88) ? SHAPE_POOL : SHAPE_NOISE;
      ntri = $urandom_range(1, 8);
      send_surface(shape, ntri);
      sent += ntri;
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_vertex_count(16'hFFFF);
          1: write_vertex_count(VC_W'($urandom_range(0, 2)));
          default: write_vertex_count(VC_W'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_table_overflow();
    // 72 distinct edges against 64 entries; the next surface must start clean
    send_surface(SHAPE_NOISE, 24);
    send_surface(SHAPE_FAN, 4);
    send_surface(SHAPE_STRIP, 6);
    send_surface(SHAPE_POOL, 3);
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 300;
    send_surface(SHAPE_FAN, 5);
    send_surface(SHAPE_STRIP, 4);
    send_surface(SHAPE_NOISE, 3);
  endtask

  task automatic test_streaming();
    wait_idle();
    quiet = 1'b1;
    test_random_surfaces(10);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    vertex_a_i = '0;
    vertex_b_i = '0;
    vertex_c_i = '0;
    final_triangle_i = 1'b0;
    out_stall_i = 1'b0;
    quiet = 1'b0;
    hold_cycles = 0;
    vtx_count = efd_pkg::VERTEX_COUNT_RESET;
    fill = 0;
    dropped = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_triangles();
    test_shared_and_closed();
    test_vertex_count_extremes();
    test_random_surfaces(20);
    test_table_overflow();
    test_output_backpressure();
    test_streaming();
    wait_idle();

    if (failures == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/efd_pkg.sv
sv/efd_lane.sv
sv/efd_merge.sv
sv/mesh_boundary_edge_finder.sv
sv/efd_checker.sv
dv/testbench.sv
